// ----- hdl/mng_pkg.sv -----
// ============================================================================
// mng_pkg: shared types and constants of the Manhattan neighbour generator
// Holds the job and result records, the state encodings, the register
// indexes and the grid size helper used across the generator's modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mng_pkg;

  localparam int unsigned MaxReach  = 5;
  localparam int unsigned MaxDim    = 1024;
  localparam int unsigned CoordW    = 10;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned ReachW    = 3;
  localparam int unsigned OffW      = 4;
  localparam int unsigned CalcW     = 12;
  localparam int unsigned DivSteps  = CoordW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam int unsigned JobDepth  = 2;
  localparam int unsigned JobPtrW   = $clog2(JobDepth);
  localparam int unsigned OutDepth  = 2;
  localparam int unsigned OutPtrW   = $clog2(OutDepth);
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_HEIGHT = 2'd0,
    REG_GRID_WIDTH  = 2'd1,
    REG_WRAP_MODE   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FLUSH
  } back_state_e;

  typedef struct packed {
    logic [SizeW-1:0] height;
    logic [SizeW-1:0] width;
    logic             wrap;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row_mod;
    logic [CoordW-1:0] col_mod;
    logic [ReachW-1:0] reach;
  } job_t;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              found;
    logic              last;
  } result_t;

  function automatic logic [SizeW-1:0] grid_size(input logic [SizeW-1:0] reg_val);
    logic [SizeW-1:0] size;
    size = reg_val;
    if (reg_val == '0) begin
      size = SizeW'(1);
    end else if (reg_val > SizeW'(MaxDim)) begin
      size = SizeW'(MaxDim);
    end
    return size;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mng_front.sv -----
// ============================================================================
// mng_front: request intake and centre reduction
// Takes one request, saturates its reach and reduces both centre coordinates
// modulo the grid size, one quotient bit per cycle, then hands a job on.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mng_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  mng_pkg::cfg_t                 cfg_i,
  input  wire                           push,
  output logic                          full,
  input  wire [mng_pkg::CoordW-1:0]     center_row_i,
  input  wire [mng_pkg::CoordW-1:0]     center_col_i,
  input  wire [mng_pkg::ReachW-1:0]     reach_i,
  output logic                          job_push_o,
  output mng_pkg::job_t                 job_o,
  input  wire                           job_full_i
);

  mng_pkg::front_state_e state_q, state_d;
  logic [mng_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [mng_pkg::CoordW-1:0]  row_q, row_d, col_q, col_d;
  logic [mng_pkg::ReachW-1:0]  reach_q, reach_d;
  logic [mng_pkg::SizeW-1:0]   rrem_q, rrem_d, crem_q, crem_d;
  logic [mng_pkg::CalcW-1:0]   rshift, cshift;
  logic                        accept;

  assign accept = push && !full;

  always_comb begin
    rshift = {rrem_q, row_q[cnt_q]};
    cshift = {crem_q, col_q[cnt_q]};
    if (rshift >= mng_pkg::CalcW'(cfg_i.height)) begin
      rshift = rshift - mng_pkg::CalcW'(cfg_i.height);
    end
    if (cshift >= mng_pkg::CalcW'(cfg_i.width)) begin
      cshift = cshift - mng_pkg::CalcW'(cfg_i.width);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mng_pkg::FR_IDLE: begin
        if (accept) begin
          state_d = mng_pkg::FR_DIV;
        end
      end
      mng_pkg::FR_DIV: begin
        if (cnt_q == '0) begin
          state_d = mng_pkg::FR_PUSH;
        end
      end
      mng_pkg::FR_PUSH: begin
        if (!job_full_i) begin
          state_d = mng_pkg::FR_IDLE;
        end
      end
      default: state_d = mng_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    row_d   = row_q;
    col_d   = col_q;
    reach_d = reach_q;
    rrem_d  = rrem_q;
    crem_d  = crem_q;
    full       = 1'b1;
    job_push_o = 1'b0;
    case (state_q)
      mng_pkg::FR_IDLE: begin
        full = 1'b0;
        if (accept) begin
          row_d  = center_row_i;
          col_d  = center_col_i;
          cnt_d  = mng_pkg::DivCntW'(mng_pkg::DivSteps - 1);
          rrem_d = '0;
          crem_d = '0;
          if (reach_i > mng_pkg::ReachW'(mng_pkg::MaxReach)) begin
            reach_d = mng_pkg::ReachW'(mng_pkg::MaxReach);
          end else begin
            reach_d = reach_i;
          end
        end
      end
      mng_pkg::FR_DIV: begin
        rrem_d = rshift[mng_pkg::SizeW-1:0];
        crem_d = cshift[mng_pkg::SizeW-1:0];
        cnt_d  = cnt_q - 1'b1;
      end
      mng_pkg::FR_PUSH: begin
        job_push_o = !job_full_i;
      end
      default: full = 1'b1;
    endcase
  end

  always_comb begin
    job_o.row     = row_q;
    job_o.col     = col_q;
    job_o.row_mod = rrem_q[mng_pkg::CoordW-1:0];
    job_o.col_mod = crem_q[mng_pkg::CoordW-1:0];
    job_o.reach   = reach_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mng_pkg::FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    col_q   <= col_d;
    reach_q <= reach_d;
    rrem_q  <= rrem_d;
    crem_q  <= crem_d;
  end

endmodule

`default_nettype wire

// ----- hdl/mng_job_queue.sv -----
// ============================================================================
// mng_job_queue: short job queue between the front and back parts
// A small first-in first-out buffer of reduced requests.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mng_job_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  mng_pkg::job_t  job_i,
  output logic           full_o,
  input  wire            pop_i,
  output mng_pkg::job_t  job_o,
  output logic           valid_o
);

  mng_pkg::job_t                 mem_q [mng_pkg::JobDepth];
  logic [mng_pkg::JobPtrW-1:0]   wr_q, rd_q;
  logic [mng_pkg::JobPtrW:0]     cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == (mng_pkg::JobPtrW+1)'(mng_pkg::JobDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mng_back.sv -----
// ============================================================================
// mng_back: neighbour enumeration and result buffer
// Walks the offsets of one job, one per cycle unless a full result buffer stalls it, wraps or clips each position,
// holds back one kept neighbour to mark the last one, and buffers results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mng_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  mng_pkg::cfg_t              cfg_i,
  input  wire                        job_valid_i,
  input  mng_pkg::job_t              job_i,
  output logic                       job_pop_o,
  output logic                       empty,
  input  wire                        pop,
  output logic [mng_pkg::CoordW-1:0] neighbor_row_o,
  output logic [mng_pkg::CoordW-1:0] neighbor_col_o,
  output logic                       found_o,
  output logic                       last_o
);

  typedef logic signed [mng_pkg::OffW-1:0]  off_t;
  typedef logic signed [mng_pkg::CalcW-1:0] calc_t;

  mng_pkg::back_state_e state_q, state_d;
  off_t                 dr_q, dr_d, dc_q, dc_d;
  mng_pkg::result_t     pend_q, pend_d;
  logic                 pend_vld_q, pend_vld_d;

  mng_pkg::result_t             out_q [mng_pkg::OutDepth];
  logic [mng_pkg::OutPtrW-1:0]  owr_q, ord_q;
  logic [mng_pkg::OutPtrW:0]    ocnt_q, ocnt_d;
  logic                         opush, opop, ospace;
  mng_pkg::result_t             opush_data;

  off_t             reach_s, span, dr_next, span_next;
  logic             row_end, final_off, kept, row_ok, col_ok;
  mng_pkg::result_t cand;
  logic [mng_pkg::CoordW-1:0] row_v, col_v;

  function automatic logic [mng_pkg::CoordW-1:0] wrap_coord(
    input logic [mng_pkg::CoordW-1:0] base,
    input off_t                       off,
    input logic [mng_pkg::SizeW-1:0]  size
  );
    calc_t v;
    calc_t n;
    v = $signed({2'b00, base}) + calc_t'(off);
    n = $signed({1'b0, size});
    for (int i = 0; i < mng_pkg::MaxReach; i++) begin
      if (v < 0) begin
        v = v + n;
      end else if (v >= n) begin
        v = v - n;
      end
    end
    return v[mng_pkg::CoordW-1:0];
  endfunction

  function automatic logic clip_ok(
    input logic [mng_pkg::CoordW-1:0] base,
    input off_t                       off,
    input logic [mng_pkg::SizeW-1:0]  size
  );
    calc_t v;
    v = $signed({2'b00, base}) + calc_t'(off);
    return (v >= 0) && (v < $signed({1'b0, size}));
  endfunction

  assign reach_s   = $signed({1'b0, job_i.reach});
  assign span      = reach_s - ((dr_q < 0) ? -dr_q : dr_q);
  assign dr_next   = dr_q + off_t'(1);
  assign span_next = reach_s - ((dr_next < 0) ? -dr_next : dr_next);
  assign row_end   = (dc_q == span);
  assign final_off = row_end && (dr_q == reach_s);

  always_comb begin
    if (cfg_i.wrap) begin
      row_v  = wrap_coord(job_i.row_mod, dr_q, cfg_i.height);
      col_v  = wrap_coord(job_i.col_mod, dc_q, cfg_i.width);
      row_ok = 1'b1;
      col_ok = 1'b1;
    end else begin
      row_v  = job_i.row + mng_pkg::CoordW'(dr_q);
      col_v  = job_i.col + mng_pkg::CoordW'(dc_q);
      row_ok = clip_ok(job_i.row, dr_q, cfg_i.height);
      col_ok = clip_ok(job_i.col, dc_q, cfg_i.width);
    end
    cand.row   = row_v;
    cand.col   = col_v;
    cand.found = 1'b1;
    cand.last  = 1'b0;
    kept = row_ok && col_ok && !((dr_q == 0) && (dc_q == 0));
  end

  assign ospace = (ocnt_q != (mng_pkg::OutPtrW+1)'(mng_pkg::OutDepth));

  always_comb begin
    state_d = state_q;
    case (state_q)
      mng_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_i.reach == '0) ? mng_pkg::BK_FLUSH : mng_pkg::BK_RUN;
        end
      end
      mng_pkg::BK_RUN: begin
        if (!(kept && pend_vld_q && !ospace) && final_off) begin
          state_d = mng_pkg::BK_FLUSH;
        end
      end
      mng_pkg::BK_FLUSH: begin
        if (ospace) begin
          state_d = mng_pkg::BK_IDLE;
        end
      end
      default: state_d = mng_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    dr_d       = dr_q;
    dc_d       = dc_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    opush      = 1'b0;
    opush_data = pend_q;
    job_pop_o  = 1'b0;
    case (state_q)
      mng_pkg::BK_IDLE: begin
        dr_d       = -reach_s;
        dc_d       = '0;
        pend_vld_d = 1'b0;
      end
      mng_pkg::BK_RUN: begin
        if (!(kept && pend_vld_q && !ospace)) begin
          if (kept) begin
            opush      = pend_vld_q;
            pend_d     = cand;
            pend_vld_d = 1'b1;
          end
          if (row_end) begin
            dr_d = dr_next;
            dc_d = -span_next;
          end else begin
            dc_d = dc_q + off_t'(1);
          end
        end
      end
      mng_pkg::BK_FLUSH: begin
        opush = ospace;
        if (pend_vld_q) begin
          opush_data.last = 1'b1;
        end else begin
          opush_data = '{row: '0, col: '0, found: 1'b0, last: 1'b1};
        end
        if (ospace) begin
          job_pop_o  = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: begin
        opush = 1'b0;
      end
    endcase
  end

  assign empty = (ocnt_q == '0);
  assign opop  = pop && !empty;

  always_comb begin
    ocnt_d = ocnt_q;
    if (opush && !opop) begin
      ocnt_d = ocnt_q + 1'b1;
    end else if (opop && !opush) begin
      ocnt_d = ocnt_q - 1'b1;
    end
  end

  assign neighbor_row_o = out_q[ord_q].row;
  assign neighbor_col_o = out_q[ord_q].col;
  assign found_o        = out_q[ord_q].found;
  assign last_o         = out_q[ord_q].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mng_pkg::BK_IDLE;
      pend_vld_q <= 1'b0;
      owr_q      <= '0;
      ord_q      <= '0;
      ocnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      ocnt_q     <= ocnt_d;
      if (opush) begin
        owr_q <= owr_q + 1'b1;
      end
      if (opop) begin
        ord_q <= ord_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q   <= dr_d;
    dc_q   <= dc_d;
    pend_q <= pend_d;
    if (opush) begin
      out_q[owr_q] <= opush_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/manhattan_neighbor_generator.sv -----
// ============================================================================
// manhattan_neighbor_generator: von Neumann neighbourhood enumeration
// Lists every cell within a Manhattan reach of a centre cell, the centre apart, either
// wrapped onto a torus or clipped at the grid edges.
// ============================================================================
//
//   Channel   Direction  Handshake     Transfer when
//   request   in         push / full   push high and full low
//   result    out        pop / empty   pop high and empty low
//   config    in         cfg_we_i      cfg_we_i high
//
// A request passes through the front part, which reduces the centre one
// remainder bit per cycle. The back part takes up the job, walks
// 2*r*r+2*r+1 offsets for reach r, one per cycle unless a full result
// buffer stalls the walk, and then closes the job. A full job queue stalls
// the front, which can take the next request while the back part walks.
// Reset leaves the block idle with a 64 by 64 clipped grid.
//
`timescale 1ns / 1ps
`default_nettype none

module manhattan_neighbor_generator (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [mng_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  wire [mng_pkg::SizeW-1:0]             cfg_data_i,
  input  wire                                  push,
  output logic                                 full,
  input  wire [mng_pkg::CoordW-1:0]            center_row_i,
  input  wire [mng_pkg::CoordW-1:0]            center_col_i,
  input  wire [mng_pkg::ReachW-1:0]            reach_i,
  output logic                                 empty,
  input  wire                                  pop,
  output logic [mng_pkg::CoordW-1:0]           neighbor_row_o,
  output logic [mng_pkg::CoordW-1:0]           neighbor_col_o,
  output logic                                 found_o,
  output logic                                 last_o
);

  logic [mng_pkg::SizeW-1:0] height_q, width_q;
  logic                      wrap_q;
  mng_pkg::cfg_t             cfg;
  logic                      fr_push, q_full, q_pop, q_valid;
  mng_pkg::job_t             fr_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= mng_pkg::SizeW'(64);
      width_q  <= mng_pkg::SizeW'(64);
      wrap_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (mng_pkg::reg_idx_e'(cfg_idx_i))
        mng_pkg::REG_GRID_HEIGHT: height_q <= cfg_data_i;
        mng_pkg::REG_GRID_WIDTH:  width_q  <= cfg_data_i;
        mng_pkg::REG_WRAP_MODE:   wrap_q   <= cfg_data_i[0];
        default: wrap_q <= wrap_q;
      endcase
    end
  end

  assign cfg.height = mng_pkg::grid_size(height_q);
  assign cfg.width  = mng_pkg::grid_size(width_q);
  assign cfg.wrap   = wrap_q;

  mng_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .push         (push),
    .full         (full),
    .center_row_i (center_row_i),
    .center_col_i (center_col_i),
    .reach_i      (reach_i),
    .job_push_o   (fr_push),
    .job_o        (fr_job),
    .job_full_i   (q_full)
  );

  mng_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .job_i   (fr_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_job),
    .valid_o (q_valid)
  );

  mng_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .job_valid_i    (q_valid),
    .job_i          (q_job),
    .job_pop_o      (q_pop),
    .empty          (empty),
    .pop            (pop),
    .neighbor_row_o (neighbor_row_o),
    .neighbor_col_o (neighbor_col_o),
    .found_o        (found_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ----- hdl/mng_checker.sv -----
// ============================================================================
// mng_checker: port-level checks of the Manhattan neighbour generator
// Watches the request and result queues and flags illegal sequences.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mng_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              push,
  input wire                              full,
  input wire                              empty,
  input wire                              pop,
  input wire [mng_pkg::CoordW-1:0]        neighbor_row_o,
  input wire [mng_pkg::CoordW-1:0]        neighbor_col_o,
  input wire                              found_o,
  input wire                              last_o
);

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> last_o)
    else $error("Empty marker without last flag.");

  a_marker_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !found_o) |-> (neighbor_row_o == '0 && neighbor_col_o == '0))
    else $error("Empty marker with non-zero coordinates.");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("Request intake not busy after a transfer.");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(neighbor_row_o) && $stable(neighbor_col_o)
                          && $stable(found_o) && $stable(last_o)))
    else $error("Waiting result changed before its transfer.");

endmodule

bind manhattan_neighbor_generator mng_checker u_mng_checker (.*);

`default_nettype wire
